FILE: rtl/clt_pkg.sv
// Shared types and constants for the command line tokenizer.
package clt_pkg;

  localparam int unsigned CHAR_W   = 7;
  localparam int unsigned IDX_W    = 5;
  localparam int unsigned QDEPTH   = 4;
  localparam int unsigned QAW      = 2;
  localparam int unsigned QCNT_W   = 3;

  localparam logic [CHAR_W-1:0] CH_BACKSLASH = 7'h5C;
  localparam logic [CHAR_W-1:0] CH_QUOTE     = 7'h22;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 7'h20;
  localparam logic [IDX_W-1:0]  LIMIT_RESET  = 5'd16;

  typedef enum logic [1:0] {
    KIND_CHAR    = 2'd0,
    KIND_END     = 2'd1,
    KIND_DISCARD = 2'd2,
    KIND_LINE    = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [CHAR_W-1:0] ch;
    logic [IDX_W-1:0]  idx;
  } result_t;

  // results of one input word; cnt is 1..3 when queued
  typedef struct packed {
    logic [1:0]         cnt;
    result_t [2:0]      res;
  } plan_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

FILE: rtl/clt_front.sv
// Front end: takes input words, runs the quoting state and builds result plans.
module clt_front import clt_pkg::*; #(
  parameter int unsigned MAX_TOKENS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [IDX_W-1:0]  cfg_wr_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CHAR_W-1:0] in_char,
  input  logic              in_line_end,
  input  q_status_t         q_status,
  output logic              push,
  output plan_t             push_plan
);

  localparam logic [IDX_W-1:0] LIM_CAP = (MAX_TOKENS > 31) ? 5'd31 : IDX_W'(MAX_TOKENS);

  logic [IDX_W-1:0] token_limit_r;
  logic             in_quotes_r, in_quotes_nxt;
  logic             esc_r, esc_nxt;
  logic             acq_r, acq_nxt;
  logic [IDX_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] limit;
  logic             under;
  logic [1:0]       n;
  plan_t            plan;
  logic             accept;

  assign limit    = (token_limit_r > LIM_CAP) ? LIM_CAP : token_limit_r;
  assign under    = count_r < limit;
  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    plan          = '0;
    n             = 2'd0;
    in_quotes_nxt = in_quotes_r;
    esc_nxt       = esc_r;
    acq_nxt       = acq_r;
    count_nxt     = count_r;
    if (in_line_end) begin
      if (under) begin
        if (esc_r && !acq_r) begin
          plan.res[n] = '{KIND_CHAR, CH_BACKSLASH, count_r};
          n = n + 2'd1;
        end
        plan.res[n] = '{KIND_END, '0, count_r};
        n = n + 2'd1;
        count_nxt = count_r + 5'd1;
      end
      plan.res[n] = '{KIND_LINE, '0, count_nxt};
      n = n + 2'd1;
      in_quotes_nxt = 1'b0;
      esc_nxt       = 1'b0;
      acq_nxt       = 1'b0;
      count_nxt     = '0;
    end else if (under) begin
      if (in_char == CH_BACKSLASH) begin
        if (esc_r && !acq_r) begin
          plan.res[n] = '{KIND_CHAR, CH_BACKSLASH, count_r};
          n = n + 2'd1;
        end
        esc_nxt = 1'b1;
      end else if (in_char == CH_QUOTE) begin
        if (esc_r) begin
          // escaped quote is literal
          if (!acq_r) begin
            plan.res[n] = '{KIND_CHAR, CH_QUOTE, count_r};
            n = n + 2'd1;
          end
        end else if (!in_quotes_r) begin
          plan.res[n] = '{KIND_DISCARD, '0, count_r};
          n = n + 2'd1;
          in_quotes_nxt = 1'b1;
          acq_nxt       = 1'b0;
        end else begin
          in_quotes_nxt = 1'b0;
          acq_nxt       = 1'b1;
        end
        esc_nxt = 1'b0;
      end else if (in_char == CH_SPACE && !in_quotes_r) begin
        if (esc_r && !acq_r) begin
          plan.res[n] = '{KIND_CHAR, CH_BACKSLASH, count_r};
          n = n + 2'd1;
        end
        plan.res[n] = '{KIND_END, '0, count_r};
        n = n + 2'd1;
        count_nxt = count_r + 5'd1;
        acq_nxt   = 1'b0;
        esc_nxt   = 1'b0;
      end else begin
        if (!acq_r) begin
          if (esc_r) begin
            plan.res[n] = '{KIND_CHAR, CH_BACKSLASH, count_r};
            n = n + 2'd1;
          end
          plan.res[n] = '{KIND_CHAR, in_char, count_r};
          n = n + 2'd1;
        end
        esc_nxt = 1'b0;
      end
    end
    plan.cnt = n;
  end

  assign push      = accept && (n != 2'd0);
  assign push_plan = plan;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      token_limit_r <= LIMIT_RESET;
      in_quotes_r   <= 1'b0;
      esc_r         <= 1'b0;
      acq_r         <= 1'b0;
      count_r       <= '0;
    end else begin
      if (cfg_wr_en) begin
        token_limit_r <= cfg_wr_data;
      end
      if (accept) begin
        in_quotes_r <= in_quotes_nxt;
        esc_r       <= esc_nxt;
        acq_r       <= acq_nxt;
        count_r     <= count_nxt;
      end
    end
  end

endmodule

FILE: rtl/clt_queue.sv
// Small queue of result plans between front end and back end.
module clt_queue import clt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  plan_t     push_plan,
  input  logic      pop,
  output plan_t     head,
  output q_status_t status
);

  plan_t             mem_r [QDEPTH];
  logic [QAW-1:0]    wr_ptr_r;
  logic [QAW-1:0]    rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign head         = mem_r[rd_ptr_r];
  assign status.empty = (cnt_r == '0);
  assign status.full  = (cnt_r == QCNT_W'(QDEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_plan;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

FILE: rtl/clt_back.sv
// Back end: walks the head plan one result per cycle, while the output is not stalled, into the output register.
module clt_back import clt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  plan_t             head,
  input  q_status_t         q_status,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_kind,
  output logic [CHAR_W-1:0] out_char,
  output logic [IDX_W-1:0]  out_token_index,
  output logic              out_last
);

  logic             out_valid_r;
  result_t          res_r;
  logic             last_r;
  logic [1:0]       sub_r;
  logic             load;
  logic             is_last;
  result_t          cur;

  assign load    = !q_status.empty && (!out_valid_r || out_ready);
  assign cur     = head.res[sub_r];
  assign is_last = (sub_r == (head.cnt - 2'd1));
  assign pop     = load && is_last;

  always_ff @(posedge clk) begin
    if (load) begin
      res_r  <= cur;
      last_r <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sub_r       <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        sub_r       <= is_last ? 2'd0 : sub_r + 2'd1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = res_r.kind;
  assign out_char        = res_r.ch;
  assign out_token_index = res_r.idx;
  assign out_last        = last_r;

endmodule

FILE: rtl/command_line_tokenizer.sv
// A taken word's results are written to the plan queue, then loaded into the output register.
// The output gives one result word per cycle while not stalled; an input word producing
// k results (0..3) occupies the output for k result words.
// A 4-entry plan queue lets input accept continue while the output is stalled.
// Reset (rst_n low, synchronous): quoting state and token count cleared,
// token limit set to 16, queue and output register emptied.
module command_line_tokenizer import clt_pkg::*; #(
  parameter int unsigned MAX_TOKENS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [IDX_W-1:0]  cfg_wr_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CHAR_W-1:0] in_char,
  input  logic              in_line_end,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_kind,
  output logic [CHAR_W-1:0] out_char,
  output logic [IDX_W-1:0]  out_token_index,
  output logic              out_last
);

  logic      push;
  plan_t     push_plan;
  logic      pop;
  plan_t     head;
  q_status_t q_status;

  clt_front #(.MAX_TOKENS(MAX_TOKENS)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_char     (in_char),
    .in_line_end (in_line_end),
    .q_status    (q_status),
    .push        (push),
    .push_plan   (push_plan)
  );

  clt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_plan (push_plan),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  clt_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .q_status        (q_status),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_char        (out_char),
    .out_token_index (out_token_index),
    .out_last        (out_last)
  );

endmodule

FILE: rtl/clt_checker.sv
// Port-level checks for the command line tokenizer, bound to the top level.
module clt_checker import clt_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [1:0]        out_kind,
  input logic [CHAR_W-1:0] out_char,
  input logic [IDX_W-1:0]  out_token_index,
  input logic              out_last
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_char)
      && $stable(out_token_index) && $stable(out_last))
    else $error("output word changed while stalled");

  a_line_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_LINE |-> out_last)
    else $error("line end marker not last");

  a_discard_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_DISCARD |-> out_last)
    else $error("discard marker not alone");

  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_CHAR |-> out_char == '0)
    else $error("marker carries a character");

endmodule

bind command_line_tokenizer clt_checker u_clt_checker (.*);
